FILE: design/vtpd_pkg.sv
// shared types and constants for the vertex transform with perspective divide
package vtpd_pkg;

   localparam int PROD_W = 64;
   localparam int SUM_W  = 66;
   localparam int FRAC_W = 16;
   localparam int MAG_W  = SUM_W + FRAC_W;
   localparam int Q_W    = 32;
   localparam int CMP_W  = MAG_W + Q_W - FRAC_W + 16;
   localparam int NDIV   = 32;
   localparam int NREG   = 8;
   localparam int IDX_W  = 3;

   localparam logic OP_POINT = 1'b0;
   localparam logic OP_DIR   = 1'b1;

   localparam logic [31:0] SAT_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] SAT_MIN = 32'h8000_0000;

   localparam logic [63:0] MAT_RESET [NREG] = '{
      64'h0000_0000_0001_0000, 64'h0,
      64'h0001_0000_0000_0000, 64'h0,
      64'h0,                   64'h0000_0000_0001_0000,
      64'h0,                   64'h0001_0000_0000_0000
   };

   // one output component on its way through the divider
   typedef struct packed {
      logic [MAG_W-1:0] rem;
      logic [Q_W-1:0]   q;
      logic             neg;
      logic             sat;
      logic             nz;
   } lane_type;

   // per-transaction control travelling with the lanes
   typedef struct packed {
      logic             op;
      logic             wz;
      logic [SUM_W-1:0] den;
   } item_type;

endpackage

FILE: design/vertex_transform_persp_divide.sv
// top level: 4x4 homogeneous vertex transform with perspective divide
//
//  channel | handshake              | payload
//  req     | req_tvalid/req_tready  | tdata {z,y,x}, tuser op
//  rsp     | rsp_tvalid/rsp_tready  | tdata {z,y,x}, tuser {w_zero,overflow}
//  csr     | csr_wr_en              | csr_index, csr_wr_data
//
// 37 register stages: products, column sums, magnitudes, range check,
// 32 restoring division stages (one quotient bit each) and the output register
// one transaction per clock sustained while rsp_tready stays high
// each stage holds when full and its successor holds, so bubbles are squeezed out
// reset clears the valid bits and loads the identity matrix
module vertex_transform_persp_divide (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [95:0]  req_tdata,   // in_x, in_y, in_z
   input  logic         req_tuser,   // op
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [95:0]  rsp_tdata,   // out_x, out_y, out_z
   output logic [1:0]   rsp_tuser,   // overflow, w_zero
   input  logic         csr_wr_en,
   input  logic [vtpd_pkg::IDX_W-1:0] csr_index,
   input  logic [63:0]  csr_wr_data
);
   import vtpd_pkg::*;

   localparam int NST = 3 + NDIV + 1 + 1;
   localparam int OST = NST - 1;

   // matrix registers
   logic [63:0] mat_ff [NREG];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NREG; i++) mat_ff[i] <= MAT_RESET[i];
      end else if (csr_wr_en) begin
         mat_ff[csr_index] <= csr_wr_data;
      end
   end

   function automatic logic signed [31:0] elem(input logic [63:0] m [NREG],
                                                input int r, input int c);
      logic [63:0] w;
      w = m[r*2 + c/2];
      return (c % 2 == 1) ? w[63:32] : w[31:0];
   endfunction

   // stage handshake: a stage loads when empty or when its successor moves
   logic [NST-1:0] vld_ff;
   logic [NST:0]   rdy;

   always_comb begin
      rdy[NST] = rsp_tready;
      for (int k = NST-1; k >= 0; k--) rdy[k] = !vld_ff[k] || rdy[k+1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (rdy[0]) vld_ff[0] <= req_tvalid;
         for (int k = 1; k < NST; k++) begin
            if (rdy[k]) vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   assign req_tready = rdy[0];
   assign rsp_tvalid = vld_ff[OST];

   // stage 0: twelve products, Q32.32
   logic signed [PROD_W-1:0] prod_ff [3][4];
   logic                     op0_ff;
   logic signed [31:0]       vin [3];

   assign vin[0] = req_tdata[31:0];
   assign vin[1] = req_tdata[63:32];
   assign vin[2] = req_tdata[95:64];

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         op0_ff <= req_tuser;
         for (int r = 0; r < 3; r++)
            for (int c = 0; c < 4; c++)
               prod_ff[r][c] <= PROD_W'(vin[r]) * PROD_W'(elem(mat_ff, r, c));
      end
   end

   // stage 1: column sums, translation row only for points
   logic signed [SUM_W-1:0] sum_ff [4];
   logic                    op1_ff;
   logic signed [SUM_W-1:0] sum_in [4];

   always_comb begin
      for (int c = 0; c < 4; c++) begin
         sum_in[c] = SUM_W'(prod_ff[0][c]) + SUM_W'(prod_ff[1][c]) + SUM_W'(prod_ff[2][c]);
         if (op0_ff == OP_POINT)
            sum_in[c] = sum_in[c] + (SUM_W'(elem(mat_ff, 3, c)) <<< FRAC_W);
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[1]) begin
         op1_ff <= op0_ff;
         for (int c = 0; c < 4; c++) sum_ff[c] <= sum_in[c];
      end
   end

   // stage 2: magnitudes and signs; directions are finished here
   lane_type lane2_ff [3];
   item_type item2_ff;
   lane_type lane2_in [3];
   item_type item2_in;

   always_comb begin
      logic signed [SUM_W-FRAC_W-1:0] sh;
      logic [SUM_W-1:0]               mag;
      item2_in.op  = op1_ff;
      item2_in.wz  = (op1_ff == OP_POINT) && (sum_ff[3] == '0);
      item2_in.den = sum_ff[3][SUM_W-1] ? SUM_W'(-sum_ff[3]) : sum_ff[3];
      for (int c = 0; c < 3; c++) begin
         mag = sum_ff[c][SUM_W-1] ? SUM_W'(-sum_ff[c]) : sum_ff[c];
         lane2_in[c].rem = {mag, {FRAC_W{1'b0}}};
         lane2_in[c].neg = sum_ff[c][SUM_W-1] ^ sum_ff[3][SUM_W-1];
         lane2_in[c].nz  = (sum_ff[c] != '0);
         sh = sum_ff[c][SUM_W-1:FRAC_W];
         if (op1_ff == OP_DIR) begin
            if (sh > $signed({{(SUM_W-FRAC_W-32){1'b0}}, SAT_MAX})) begin
               lane2_in[c].q = SAT_MAX;  lane2_in[c].sat = 1'b1;
            end else if (sh < $signed({{(SUM_W-FRAC_W-32){1'b1}}, SAT_MIN})) begin
               lane2_in[c].q = SAT_MIN;  lane2_in[c].sat = 1'b1;
            end else begin
               lane2_in[c].q = sh[31:0]; lane2_in[c].sat = 1'b0;
            end
         end else begin
            lane2_in[c].q   = '0;
            lane2_in[c].sat = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[2]) begin
         item2_ff <= item2_in;
         for (int c = 0; c < 3; c++) lane2_ff[c] <= lane2_in[c];
      end
   end

   // division pipe: record 0 is the range check, records 1..NDIV one quotient bit each
   lane_type dlane_ff [NDIV+1][3];
   item_type ditem_ff [NDIV+1];
   lane_type range_in [3];

   // range check: a quotient of 2^32 or more always saturates
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         range_in[c] = lane2_ff[c];
         if (item2_ff.op == OP_POINT && !item2_ff.wz &&
             {{(CMP_W-MAG_W){1'b0}}, lane2_ff[c].rem} >=
             ({{(CMP_W-SUM_W){1'b0}}, item2_ff.den} << Q_W))
            range_in[c].sat = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[3]) begin
         ditem_ff[0] <= item2_ff;
         for (int c = 0; c < 3; c++) dlane_ff[0][c] <= range_in[c];
      end
   end

   for (genvar k = 1; k <= NDIV; k++) begin : g_div
      localparam int BIT = NDIV - k;
      lane_type lane_in [3];
      logic [CMP_W-1:0] dsh;
      logic [CMP_W-1:0] rext;

      always_comb begin
         dsh  = {{(CMP_W-SUM_W){1'b0}}, ditem_ff[k-1].den} << BIT;
         rext = '0;
         for (int c = 0; c < 3; c++) begin
            lane_in[c] = dlane_ff[k-1][c];
            rext = {{(CMP_W-MAG_W){1'b0}}, dlane_ff[k-1][c].rem};
            if (ditem_ff[k-1].op == OP_POINT && !ditem_ff[k-1].wz &&
                !dlane_ff[k-1][c].sat && rext >= dsh) begin
               lane_in[c].rem    = MAG_W'(rext - dsh);
               lane_in[c].q[BIT] = 1'b1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (rdy[3+k]) begin
            ditem_ff[k] <= ditem_ff[k-1];
            for (int c = 0; c < 3; c++) dlane_ff[k][c] <= lane_in[c];
         end
      end
   end

   // output stage: sign, saturation and the zero-w special case
   logic [95:0] out_data_ff;
   logic [1:0]  out_user_ff;
   logic [95:0] out_data_in;
   logic [1:0]  out_user_in;

   always_comb begin
      lane_type   ln;
      logic       ov;
      logic [31:0] val;
      ov  = 1'b0;
      val = '0;
      ln  = dlane_ff[NDIV][0];
      for (int c = 0; c < 3; c++) begin
         ln = dlane_ff[NDIV][c];
         if (ditem_ff[NDIV].op == OP_DIR) begin
            val = ln.q;
            ov  = ov | ln.sat;
         end else if (ditem_ff[NDIV].wz) begin
            // w is zero, so neg is the numerator's own sign
            val = !ln.nz ? '0 : (ln.neg ? SAT_MIN : SAT_MAX);
            ov  = ov | ln.nz;
         end else if (ln.sat) begin
            val = ln.neg ? SAT_MIN : SAT_MAX;
            ov  = 1'b1;
         end else if (!ln.neg) begin
            val = ln.q[31] ? SAT_MAX : ln.q;
            ov  = ov | ln.q[31];
         end else if (ln.q > SAT_MIN) begin
            val = SAT_MIN;
            ov  = 1'b1;
         end else begin
            val = 32'(-ln.q);
         end
         out_data_in[c*32 +: 32] = val;
      end
      out_user_in = {ditem_ff[NDIV].wz, ov};
   end

   always_ff @(posedge clock) begin
      if (rdy[OST]) begin
         out_data_ff <= out_data_in;
         out_user_ff <= out_user_in;
      end
   end

   assign rsp_tdata = out_data_ff;
   assign rsp_tuser = out_user_ff;

endmodule

FILE: design/vtpd_checker.sv
// port-level checker for the vertex transform, bound to the top level
module vtpd_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [95:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);

   // a stalled result transaction holds its payload
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // zero w without overflow means every numerator was zero
   a_wz: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] && !rsp_tuser[0] |-> rsp_tdata == '0)
      else $error("zero w result not zero");

   // nothing leaves the pipe right after reset
   a_rst: assert property (@(posedge clock) $past(reset) |-> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind vertex_transform_persp_divide vtpd_checker u_vtpd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

FILE: test/testbench.sv
// testbench for the vertex transform with perspective divide, checked against its own predictor
module testbench;
   import vtpd_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 60;    // idle clocks after the last result, to let the pipeline empty
   localparam int PHASE_ITEMS    = 100;
   localparam int NPHASE         = 8;

   // one result transaction as the block presents it
   typedef struct packed {
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
      logic        overflow;
      logic        w_zero;
   } vertex_result_type;

   // a row of the directed table
   typedef struct {
      logic              op;
      logic [31:0]       x;
      logic [31:0]       y;
      logic [31:0]       z;
      bit                typed;   // expectation written in below rather than predicted
      vertex_result_type res;
   } vertex_row_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [95:0]  req_tdata;
   logic         req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [95:0]  rsp_tdata;
   logic [1:0]   rsp_tuser;
   logic         csr_wr_en;
   logic [IDX_W-1:0] csr_index;
   logic [63:0]  csr_wr_data;

   vertex_result_type pending_results[$];
   logic [63:0]       matrix_shadow[NREG];
   vertex_result_type typed_next[$];     // typed expectations waiting for their transaction
   int                fail_count;
   int                idle_count;
   int                send_idle_pct;
   int                stall_pct;
   bit                run_done;

   vertex_transform_persp_divide i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // matrix element, Q16.16, from the shadow copy of the registers
   function automatic logic signed [127:0] mat_elem(int r, int c);
      logic signed [31:0] e;
      logic [63:0]        word;
      word = matrix_shadow[r * 2 + c / 2];
      e = (c % 2) ? word[63:32] : word[31:0];
      return e;
   endfunction

   // Q32.32 dot product of the vector with one column, translation row optional
   function automatic logic signed [127:0] column_dot(logic signed [31:0] vx,
         logic signed [31:0] vy, logic signed [31:0] vz, int c, bit with_row3);
      logic signed [127:0] ex, ey, ez, acc;
      ex = vx;
      ey = vy;
      ez = vz;
      acc = ex * mat_elem(0, c) + ey * mat_elem(1, c) + ez * mat_elem(2, c);
      if (with_row3) acc = acc + (mat_elem(3, c) <<< 16);
      return acc;
   endfunction

   function automatic logic [31:0] clamp_q16(logic signed [127:0] v, ref logic ov);
      if (v > 128'sh7FFF_FFFF) begin
         ov = 1'b1;
         return SAT_MAX;
      end
      if (v < -128'sh8000_0000) begin
         ov = 1'b1;
         return SAT_MIN;
      end
      return v[31:0];
   endfunction

   function automatic vertex_result_type transform_vertex(logic op, logic signed [31:0] vx,
         logic signed [31:0] vy, logic signed [31:0] vz);
      vertex_result_type   r;
      logic signed [127:0] den, num;
      logic [31:0]         comp[3];
      logic                ov;
      ov = 1'b0;
      r.w_zero = 1'b0;
      if (op == OP_DIR) begin
         for (int c = 0; c < 3; c++)
            comp[c] = clamp_q16(column_dot(vx, vy, vz, c, 1'b0) >>> 16, ov);
      end else begin
         den = column_dot(vx, vy, vz, 3, 1'b1);
         r.w_zero = (den == 0);
         for (int c = 0; c < 3; c++) begin
            num = column_dot(vx, vy, vz, c, 1'b1);
            if (den == 0) begin
               // divide by zero: sign of the numerator picks the rail
               if (num == 0) comp[c] = '0;
               else begin
                  ov = 1'b1;
                  comp[c] = (num < 0) ? SAT_MIN : SAT_MAX;
               end
            end else begin
               comp[c] = clamp_q16((num <<< 16) / den, ov);   // truncates toward zero
            end
         end
      end
      r.x = comp[0];
      r.y = comp[1];
      r.z = comp[2];
      r.overflow = ov;
      return r;
   endfunction

   // all eight matrix registers in back-to-back write cycles
   task automatic load_matrix(logic [63:0] regs[NREG]);
      for (int i = 0; i < NREG; i++) begin
         csr_wr_en   <= 1'b1;
         csr_index   <= IDX_W'(i);
         csr_wr_data <= regs[i];
         matrix_shadow[i] = regs[i];
         @(posedge clock);
      end
      csr_wr_en <= 1'b0;
   endtask

   // hold the sender until every expected result is back, then let the pipe empty
   task automatic drain_results();
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic send_vertex(logic op, logic [31:0] x, logic [31:0] y, logic [31:0] z);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {z, y, x};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_element();
      case ($urandom_range(9))
         0:       return SAT_MAX;
         1:       return SAT_MIN;
         2:       return '0;
         3, 4:    return $urandom;
         default: return 32'($urandom_range(32'h8_0000)) - 32'h4_0000;   // within +-4.0
      endcase
   endfunction

   function automatic logic [31:0] pick_component();
      case ($urandom_range(9))
         0:       return SAT_MAX;
         1:       return SAT_MIN;
         2:       return '0;
         3, 4, 5: return $urandom;
         default: return 32'($urandom_range(32'h20_0000)) - 32'h10_0000;  // within +-16.0
      endcase
   endfunction

   // receiver back-pressure
   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else       rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // scoreboard: predict on every accepted request, compare on every accepted result
   always @(posedge clock) begin
      vertex_result_type got, want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            if (typed_next.size() != 0) pending_results.push_back(typed_next.pop_front());
            else pending_results.push_back(transform_vertex(req_tuser, req_tdata[31:0],
                                                            req_tdata[63:32], req_tdata[95:64]));
         end
         if (rsp_tvalid && rsp_tready) begin
            got = '{rsp_tdata[31:0], rsp_tdata[63:32], rsp_tdata[95:64],
                    rsp_tuser[0], rsp_tuser[1]};
            if (pending_results.size() == 0) begin
               $display("%0t: unexpected result transaction %h", $time, got);
               fail_count++;
            end else begin
               want = pending_results.pop_front();
               if (got.x !== want.x) begin
                  $display("%0t: out_x expected %h actual %h", $time, want.x, got.x);
                  fail_count++;
               end
               if (got.y !== want.y) begin
                  $display("%0t: out_y expected %h actual %h", $time, want.y, got.y);
                  fail_count++;
               end
               if (got.z !== want.z) begin
                  $display("%0t: out_z expected %h actual %h", $time, want.z, got.z);
                  fail_count++;
               end
               if (got.overflow !== want.overflow) begin
                  $display("%0t: overflow expected %b actual %b", $time,
                           want.overflow, got.overflow);
                  fail_count++;
               end
               if (got.w_zero !== want.w_zero) begin
                  $display("%0t: w_zero expected %b actual %b", $time,
                           want.w_zero, got.w_zero);
                  fail_count++;
               end
            end
         end
      end
   end

   // watchdog on cycles with no transaction on either channel
   always @(posedge clock) begin
      if (reset || run_done || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_count <= 0;
      else if (idle_count >= WATCHDOG_LIMIT) begin
         $display("testbench: FAIL");
         $finish;
      end else
         idle_count <= idle_count + 1;
   end

   initial begin
      vertex_row_type identity_rows[$];
      vertex_row_type wzero_rows[$];
      logic [63:0]    regs[NREG];
      logic [63:0]    no_w[NREG];
      logic [31:0]    e;

      send_idle_pct = 0;
      stall_pct     = 0;
      run_done      = 1'b0;
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tuser   <= OP_POINT;
      csr_wr_en   <= 1'b0;
      csr_index   <= '0;
      csr_wr_data <= '0;
      foreach (matrix_shadow[i]) matrix_shadow[i] = MAT_RESET[i];

      // after reset the matrix is the identity: every vector comes back unchanged
      identity_rows = '{
         '{OP_POINT, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 1,
           '{32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 1'b0, 1'b0}},
         '{OP_DIR,   32'h0001_0000, 32'hFFFE_0000, 32'h0000_8000, 1,
           '{32'h0001_0000, 32'hFFFE_0000, 32'h0000_8000, 1'b0, 1'b0}},
         '{OP_POINT, SAT_MAX, SAT_MIN, 32'h0, 1, '{SAT_MAX, SAT_MIN, 32'h0, 1'b0, 1'b0}},
         '{OP_DIR,   SAT_MIN, SAT_MAX, 32'hFFFF_FFFF, 1,
           '{SAT_MIN, SAT_MAX, 32'hFFFF_FFFF, 1'b0, 1'b0}},
         '{OP_POINT, 32'h0, 32'h0, 32'h0, 1, '{32'h0, 32'h0, 32'h0, 1'b0, 1'b0}},
         '{OP_DIR,   32'h0000_0001, 32'h8000_0001, 32'h7FFF_FFFE, 0, '{default: '0}}
      };
      // identity with w row and column cleared: every point hits the zero-w case
      wzero_rows = '{
         '{OP_POINT, 32'h0000_0005, 32'hFFFF_FFFD, 32'h0, 1, '{SAT_MAX, SAT_MIN, 32'h0, 1'b1, 1'b1}},
         '{OP_POINT, 32'h0, 32'h0, 32'h0, 1, '{32'h0, 32'h0, 32'h0, 1'b0, 1'b1}},
         '{OP_POINT, SAT_MIN, SAT_MAX, 32'h0, 1, '{SAT_MIN, SAT_MAX, 32'h0, 1'b1, 1'b1}},
         '{OP_DIR,   32'h0000_0005, 32'hFFFF_FFFD, 32'h0, 1,
           '{32'h0000_0005, 32'hFFFF_FFFD, 32'h0, 1'b0, 1'b0}},
         '{OP_DIR,   SAT_MAX, SAT_MIN, 32'h1234_5678, 0, '{default: '0}}
      };

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (identity_rows[i]) begin
         if (identity_rows[i].typed) typed_next.push_back(identity_rows[i].res);
         send_vertex(identity_rows[i].op, identity_rows[i].x, identity_rows[i].y,
                     identity_rows[i].z);
      end
      req_tvalid <= 1'b0;
      drain_results();

      foreach (no_w[i]) no_w[i] = MAT_RESET[i];
      no_w[7] = 64'h0;
      load_matrix(no_w);
      foreach (wzero_rows[i]) begin
         if (wzero_rows[i].typed) typed_next.push_back(wzero_rows[i].res);
         send_vertex(wzero_rows[i].op, wzero_rows[i].x, wzero_rows[i].y, wzero_rows[i].z);
      end
      req_tvalid <= 1'b0;
      drain_results();

      // random phases: each a fresh matrix and one idling mix
      for (int p = 0; p < NPHASE; p++) begin
         for (int i = 0; i < NREG; i++) begin
            case (p)
               0:       regs[i] = {SAT_MAX, SAT_MAX};
               1:       regs[i] = {SAT_MIN, SAT_MIN};
               7:       regs[i] = MAT_RESET[i];
               default: regs[i] = {pick_element(), pick_element()};
            endcase
         end
         if (p == 4) begin
            // no w contribution at all, so points meet the zero-w rails
            for (int r = 0; r < 4; r++) regs[r * 2 + 1][63:32] = '0;
         end
         load_matrix(regs);
         case (p % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 77; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 77; end
            default: begin send_idle_pct = 23; stall_pct = 23; end
         endcase
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (p == 2 && i == PHASE_ITEMS / 2) begin
               // sender holds off until the pipeline has handed everything back
               req_tvalid <= 1'b0;
               while (pending_results.size() != 0) @(posedge clock);
            end
            send_vertex(1'($urandom_range(1)), pick_component(), pick_component(),
                        pick_component());
         end
         req_tvalid <= 1'b0;
         drain_results();
      end

      run_done = 1'b1;
      if (fail_count == 0 && pending_results.size() == 0) $display("testbench: PASS");
      else $display("testbench: FAIL");
      $finish;
   end

endmodule

FILE: vertex_transform_persp_divide.f
design/vtpd_pkg.sv
design/vertex_transform_persp_divide.sv
design/vtpd_checker.sv
test/testbench.sv
